### rtl/core/chd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and helpers of the chained hash word dictionary.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int BUCKETS      = 65536;
  localparam int BUCKET_W     = 16;
  localparam int ENTRIES      = 4096;
  localparam int ENTRY_W      = 12;
  localparam int LINK_W       = 13;
  localparam int MAX_WORD_LEN = 45;
  localparam int LEN_W        = 6;
  localparam int TOTAL_W      = 13;
  localparam int HASH_W       = 64;
  localparam int HASH_SHIFT   = 5;
  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LONG   = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [BUCKET_W-1:0]   bucket;
    logic [LEN_W-1:0]      len;
    logic                  bank;
  } cmd_t;

  // ASCII upper case letters fold to lower case; every other byte passes.
  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

### rtl/core/chained_hash_word_dictionary_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_word_dictionary_top
// Case-insensitive word dictionary on a chained djb2 hash table.
// ----------------------------------------------------------------------------
// Words arrive one character per transfer on the slave side, with the
// operation in tuser and the final character marked by tlast. A word
// command then runs in the back: an insert links a new entry in front of
// the bucket head and copies the word, and a lookup reads the bucket head
// and walks the chain, comparing the bytes of each entry whose length
// matches, one byte at a time, through the single read port of the
// entry memories. A clear, and reset as well, sweeps all 65536 bucket heads at
// one per cycle before the next command runs; the front keeps taking
// characters until the two-entry command queue is full. One result transfer
// follows each word and each clear.
module chained_hash_word_dictionary_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_in
  input  logic [1:0]  s_tuser,   // op
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // found, accepted, too_long, word_total
);
  import chd_pkg::*;

  logic           q_full;
  logic           push;
  cmd_t           push_cmd;
  logic           pop;
  logic           head_valid;
  cmd_t           head_cmd;
  logic [LEN_W:0] buf_raddr;
  logic [7:0]     buf_rdata;

  // Front: character intake and hashing.
  chd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .buf_raddr (buf_raddr),
    .buf_rdata (buf_rdata)
  );

  // Command queue.
  chd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: table operations and result register.
  chd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .pop       (pop),
    .buf_raddr (buf_raddr),
    .buf_rdata (buf_rdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef SYNTH
  // No command is pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("command pushed into full queue");

  // The back never finishes a command that is not there.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // A result never reports a match together with an insert or a reject.
  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[2:0]) <= 1)
    else $error("conflicting result flags");

  // The stored word count never exceeds the pool size.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:3] <= 13'd4096)
    else $error("word total beyond pool size");
`endif

endmodule

### rtl/core/chd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_queue
// Two-entry command queue between the front and the back. The head stays in
// place until the back has finished it.
// ----------------------------------------------------------------------------
module chd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  chd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output chd_pkg::cmd_t head_cmd
);
  import chd_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Storage of queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slot[rd_ptr];

endmodule

### rtl/core/chd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_front
// Accepts characters, folds them into the hash, collects the word in one of
// two buffer banks and queues a command at the end of each word or on clear.
// ----------------------------------------------------------------------------
module chd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // char_in
  input  logic [1:0]                s_tuser,   // op
  input  logic                      s_tlast,   // last
  input  logic                      q_full,
  output logic                      push,
  output chd_pkg::cmd_t             push_cmd,
  input  logic [chd_pkg::LEN_W:0]   buf_raddr,
  output logic [7:0]                buf_rdata
);
  import chd_pkg::*;

  logic [HASH_W-1:0] hash;
  logic [LEN_W-1:0]  len;
  logic              ovf;
  logic              bank;
  logic [7:0]        wbuf [2**(LEN_W+1)];

  logic              accept;
  logic              is_clear;
  logic              has_room;
  logic [HASH_W-1:0] hash_next;
  logic [LEN_W-1:0]  len_next;
  logic              ovf_next;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_clear = (s_tuser == OP_CLEAR) || (s_tuser == OP_SPARE);

  // Hash step and length tracking for one character.
  always_comb begin
    hash_next = (hash << HASH_SHIFT) + hash + {{(HASH_W-8){1'b0}}, lower_byte(s_tdata)};
    has_room  = (len < LEN_W'(MAX_WORD_LEN));
    len_next  = has_room ? len + 1'b1 : len;
    ovf_next  = ovf || !has_room;
  end

  // Command toward the back.
  always_comb begin
    push            = accept && (is_clear || s_tlast);
    push_cmd.bucket = hash_next[BUCKET_W-1:0];
    push_cmd.len    = len_next;
    push_cmd.bank   = bank;
    if (is_clear) begin
      push_cmd.kind = CMD_CLEAR;
    end else if (ovf_next) begin
      push_cmd.kind = CMD_LONG;
    end else if (s_tuser == OP_INSERT) begin
      push_cmd.kind = CMD_INSERT;
    end else begin
      push_cmd.kind = CMD_LOOKUP;
    end
  end

  // Word state: restarts after each word and on clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= HASH_SEED;
      len  <= '0;
      ovf  <= 1'b0;
      bank <= 1'b0;
    end else if (accept) begin
      if (is_clear || s_tlast) begin
        hash <= HASH_SEED;
        len  <= '0;
        ovf  <= 1'b0;
        if (!is_clear) begin
          bank <= ~bank;
        end
      end else begin
        hash <= hash_next;
        len  <= len_next;
        ovf  <= ovf_next;
      end
    end
  end

  // Word buffer, written here and read by the back.
  always_ff @(posedge clk) begin
    if (accept && !is_clear && has_room) begin
      wbuf[{bank, len}] <= s_tdata;
    end
    buf_rdata <= wbuf[buf_raddr];
  end

endmodule

### rtl/core/chd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_back
// Carries out queued commands: bucket head and entry pool memories, chain
// walk with byte compare, word copy on insert, bucket sweep on clear.
// ----------------------------------------------------------------------------
module chd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  chd_pkg::cmd_t             cmd,
  output logic                      pop,
  output logic [chd_pkg::LEN_W:0]   buf_raddr,
  input  logic [7:0]                buf_rdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata    // found, accepted, too_long, word_total
);
  import chd_pkg::*;

  typedef enum logic [7:0] {
    ST_SWEEP    = 8'b00000001,
    ST_IDLE     = 8'b00000010,
    ST_INS_HEAD = 8'b00000100,
    ST_COPY     = 8'b00001000,
    ST_LK_HEAD  = 8'b00010000,
    ST_LK_ENT   = 8'b00100000,
    ST_LK_CMP   = 8'b01000000,
    ST_EMIT     = 8'b10000000
  } state_t;

  localparam int CHR_AW = ENTRY_W + LEN_W;

  // Memories.
  logic [LINK_W-1:0] heads     [BUCKETS];
  logic [7:0]        ent_chars [2**CHR_AW];
  logic [LEN_W-1:0]  ent_len   [ENTRIES];
  logic [LINK_W-1:0] ent_next  [ENTRIES];

  state_t              state, state_next;
  logic [BUCKET_W-1:0] sweep_addr, sweep_addr_next;
  logic [TOTAL_W-1:0]  pool_used, pool_used_next;
  logic [LEN_W-1:0]    cnt, cnt_next;
  logic                pend, pend_next;
  logic [LINK_W-1:0]   link, link_next;
  logic [LINK_W-1:0]   nxt, nxt_next;
  logic [ENTRY_W-1:0]  ent_idx, ent_idx_next;
  logic                go_sweep, go_sweep_next;
  logic                res_found, res_found_next;
  logic                res_acc, res_acc_next;
  logic                res_long, res_long_next;

  logic                head_we;
  logic [BUCKET_W-1:0] head_waddr;
  logic [LINK_W-1:0]   head_wdata;
  logic [LINK_W-1:0]   head_rdata;
  logic                ent_we;
  logic [ENTRY_W-1:0]  ent_waddr;
  logic [ENTRY_W-1:0]  ent_raddr;
  logic [LEN_W-1:0]    len_rdata;
  logic [LINK_W-1:0]   next_rdata;
  logic                chr_we;
  logic [CHR_AW-1:0]   chr_waddr;
  logic [CHR_AW-1:0]   chr_raddr;
  logic [7:0]          chr_rdata;
  logic                out_load;
  logic [LINK_W-1:0]   link_m1;
  logic [LINK_W-1:0]   hd_m1;
  logic [LINK_W-1:0]   nr_m1;
  logic [LINK_W-1:0]   nx_m1;

  assign link_m1 = link - 1'b1;
  assign hd_m1   = head_rdata - 1'b1;
  assign nr_m1   = next_rdata - 1'b1;
  assign nx_m1   = nxt - 1'b1;
  assign out_load = (state == ST_EMIT) && (!m_tvalid || m_tready);

  // Sequencer.
  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    pool_used_next  = pool_used;
    cnt_next        = cnt;
    pend_next       = pend;
    link_next       = link;
    nxt_next        = nxt;
    ent_idx_next    = ent_idx;
    go_sweep_next   = go_sweep;
    res_found_next  = res_found;
    res_acc_next    = res_acc;
    res_long_next   = res_long;
    head_we         = 1'b0;
    head_waddr      = cmd.bucket;
    head_wdata      = '0;
    ent_we          = 1'b0;
    ent_waddr       = ent_idx;
    ent_raddr       = '0;
    chr_we          = 1'b0;
    chr_waddr       = {ent_idx, cnt - 1'b1};
    chr_raddr       = {link_m1[ENTRY_W-1:0], cnt};
    buf_raddr       = {cmd.bank, cnt};
    pop             = 1'b0;
    unique case (state)
      ST_SWEEP: begin
        head_we         = 1'b1;
        head_waddr      = sweep_addr;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == BUCKET_W'(BUCKETS - 1)) begin
          state_next    = ST_IDLE;
          go_sweep_next = 1'b0;
        end
      end
      ST_IDLE: begin
        res_found_next = 1'b0;
        res_acc_next   = 1'b0;
        res_long_next  = 1'b0;
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_CLEAR: begin
              res_acc_next   = 1'b1;
              go_sweep_next  = 1'b1;
              pool_used_next = '0;
              state_next     = ST_EMIT;
            end
            CMD_LONG: begin
              res_long_next = 1'b1;
              state_next    = ST_EMIT;
            end
            CMD_INSERT: begin
              if (pool_used == TOTAL_W'(ENTRIES)) begin
                state_next = ST_EMIT;
              end else begin
                state_next = ST_INS_HEAD;
              end
            end
            default: begin
              state_next = ST_LK_HEAD;
            end
          endcase
        end
      end
      ST_INS_HEAD: begin
        // Link the new entry in front of the current chain head.
        ent_we         = 1'b1;
        ent_waddr      = pool_used[ENTRY_W-1:0];
        ent_idx_next   = pool_used[ENTRY_W-1:0];
        head_we        = 1'b1;
        head_wdata     = LINK_W'(pool_used + 1'b1);
        pool_used_next = pool_used + 1'b1;
        res_acc_next   = 1'b1;
        cnt_next       = '0;
        state_next     = ST_COPY;
      end
      ST_COPY: begin
        // Read byte cnt of the buffer, write byte cnt - 1 from the buffer read register.
        chr_we = (cnt != '0);
        if (cnt == cmd.len) begin
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_LK_HEAD: begin
        link_next = head_rdata;
        ent_raddr = hd_m1[ENTRY_W-1:0];
        if (head_rdata == '0) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_LK_ENT;
        end
      end
      ST_LK_ENT: begin
        if (len_rdata == cmd.len) begin
          nxt_next   = next_rdata;
          cnt_next   = '0;
          pend_next  = 1'b0;
          state_next = ST_LK_CMP;
        end else if (next_rdata == '0) begin
          state_next = ST_EMIT;
        end else begin
          link_next = next_rdata;
          ent_raddr = nr_m1[ENTRY_W-1:0];
        end
      end
      ST_LK_CMP: begin
        if (pend && (lower_byte(chr_rdata) != lower_byte(buf_rdata))) begin
          // Mismatch: move on to the next entry of the chain.
          if (nxt == '0) begin
            state_next = ST_EMIT;
          end else begin
            link_next  = nxt;
            ent_raddr  = nx_m1[ENTRY_W-1:0];
            state_next = ST_LK_ENT;
          end
        end else if (pend && (cnt == cmd.len)) begin
          res_found_next = 1'b1;
          state_next     = ST_EMIT;
        end else begin
          cnt_next  = cnt + 1'b1;
          pend_next = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          pop             = 1'b1;
          sweep_addr_next = '0;
          state_next      = go_sweep ? ST_SWEEP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      pool_used  <= '0;
      go_sweep   <= 1'b0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
      pool_used  <= pool_used_next;
      go_sweep   <= go_sweep_next;
      pend       <= pend_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Work and result registers.
  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    link      <= link_next;
    nxt       <= nxt_next;
    ent_idx   <= ent_idx_next;
    res_found <= res_found_next;
    res_acc   <= res_acc_next;
    res_long  <= res_long_next;
    if (out_load) begin
      m_tdata <= {pool_used, res_long, res_acc, res_found};
    end
  end

  // Bucket heads.
  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[head_waddr] <= head_wdata;
    end
    head_rdata <= heads[cmd.bucket];
  end

  // Entry lengths and chain links.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_len[ent_waddr]  <= cmd.len;
      ent_next[ent_waddr] <= head_rdata;
    end
    len_rdata  <= ent_len[ent_raddr];
    next_rdata <= ent_next[ent_raddr];
  end

  // Entry characters.
  always_ff @(posedge clk) begin
    if (chr_we) begin
      ent_chars[chr_waddr] <= buf_rdata;
    end
    chr_rdata <= ent_chars[chr_raddr];
  end

endmodule

### tb/sv/tb_chained_hash_word_dictionary_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_word_dictionary_top
// Self-checking testbench of the chained hash word dictionary.
// ----------------------------------------------------------------------------
// Words stream in one character per transfer. A behavioral dictionary in the
// testbench predicts each result (found, accepted, too_long, word_total) and a
// checker compares every result transfer with the oldest prediction. Named
// tests cover case folding, odd bytes, duplicates, over-long words, clears,
// a full entry pool and back pressure, together with random word traffic.
// ----------------------------------------------------------------------------
module tb_chained_hash_word_dictionary_top;
  import chd_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_WAIT  = 200;

  typedef logic [7:0] word_t[$];

  // Result fields from the highest bit down: word_total, too_long, accepted, found.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               too_long;
    logic               accepted;
    logic               found;
  } dict_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // char_in
  logic [1:0]  s_tuser;   // op
  logic        s_tlast;   // last
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // found, accepted, too_long, word_total

  // Testbench copy of the dictionary: stored words keyed by lower-case text.
  int           stored_words[string];
  int           pool_count;
  logic [7:0]   pending_word[$];
  bit           pending_long;
  dict_result_t expected_results[$];

  int errors;
  int cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int sent_items;
  word_t known_words[$];

  chained_hash_word_dictionary_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready = 1'b0;
      rx_hold--;
    end else begin
      m_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    dict_result_t got;
    dict_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer 0x%04h", m_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, got.found);
          errors++;
        end
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
          errors++;
        end
        if (got.too_long !== want.too_long) begin
          $error("too_long: expected %0d, actual %0d", want.too_long, got.too_long);
          errors++;
        end
        if (got.total !== want.total) begin
          $error("word_total: expected %0d, actual %0d", want.total, got.total);
          errors++;
        end
      end
    end
  end

  // Lower-case text of the pending word, used as the dictionary key.
  function automatic string folded_key();
    string key;
    logic [7:0] c;
    key = "";
    foreach (pending_word[i]) begin
      c = pending_word[i];
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      key = {key, $sformatf("%02x", c)};
    end
    return key;
  endfunction

  // Update the dictionary copy for one accepted character transfer.
  task automatic predict_char(input logic [1:0] op, input logic [7:0] c, input logic last);
    dict_result_t r;
    string key;
    r = '0;
    if (op == OP_CLEAR || op == OP_SPARE) begin
      stored_words.delete();
      pool_count = 0;
      pending_word.delete();
      pending_long = 1'b0;
      r.accepted = 1'b1;
      expected_results.push_back(r);
      return;
    end
    if (pending_word.size() < MAX_WORD_LEN) pending_word.push_back(c);
    else pending_long = 1'b1;
    if (!last) return;
    key = folded_key();
    if (pending_long) begin
      r.too_long = 1'b1;
    end else if (op == OP_INSERT) begin
      if (pool_count < ENTRIES) begin
        if (stored_words.exists(key)) stored_words[key]++;
        else stored_words[key] = 1;
        pool_count++;
        r.accepted = 1'b1;
      end
    end else begin
      r.found = stored_words.exists(key);
    end
    r.total = pool_count[TOTAL_W-1:0];
    expected_results.push_back(r);
    pending_word.delete();
    pending_long = 1'b0;
  endtask

  // Offer one character and hold it until the transfer completes.
  task automatic send_char(input logic [1:0] op, input logic [7:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = c;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_char(op, c, last);
    sent_items++;
  endtask

  task automatic send_word(input word_t w, input logic [1:0] op);
    foreach (w[i]) send_char(op, w[i], i == w.size() - 1);
  endtask

  function automatic word_t to_word(input string s);
    word_t w;
    for (int i = 0; i < s.len(); i++) w.push_back(s[i]);
    return w;
  endfunction

  // Wait until every prediction has been met, then let the back settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic test_case_folding();
    send_word(to_word("Ab"), OP_INSERT);
    send_word(to_word("aB"), OP_LOOKUP);
    send_word(to_word("ac"), OP_LOOKUP);
    send_word(to_word("ab"), OP_INSERT);   // duplicate adds a second entry
    send_word(to_word("@["), OP_INSERT);   // bytes just outside A-Z
    send_word(to_word("`{"), OP_LOOKUP);
  endtask

  task automatic test_odd_bytes();
    word_t w;
    w = '{8'h00, 8'hFF};
    send_word(w, OP_INSERT);
    send_word(w, OP_LOOKUP);
    // Only the operation of the last character counts.
    send_char(OP_LOOKUP, "x", 1'b0);
    send_char(OP_INSERT, "y", 1'b1);
    send_word(to_word("XY"), OP_LOOKUP);
  endtask

  task automatic test_clear();
    send_char(OP_INSERT, "q", 1'b0);
    send_char(OP_SPARE, 8'hA5, 1'b0);      // spare code acts as a clear
    send_word(to_word("ab"), OP_LOOKUP);
    send_word(to_word("ZZ"), OP_INSERT);
    send_char(OP_CLEAR, 8'h5A, 1'b1);
    drain();
  endtask

  task automatic test_word_length();
    word_t w;
    w.delete();
    for (int i = 0; i < MAX_WORD_LEN; i++) w.push_back(8'($urandom_range(65, 90)));
    send_word(w, OP_INSERT);
    send_word(w, OP_LOOKUP);
    w.push_back("k");
    send_word(w, OP_INSERT);
    send_word(w, OP_LOOKUP);
    drain();
  endtask

  task automatic test_full_pool();
    while (pool_count < ENTRIES) send_char(OP_INSERT, 8'($urandom_range(255)), 1'b1);
    send_char(OP_INSERT, "m", 1'b1);
    send_char(OP_LOOKUP, "m", 1'b1);
    send_char(OP_CLEAR, 8'h00, 1'b0);
    drain();
  endtask

  task automatic test_back_pressure();
    rx_hold = 400;
    repeat (40) send_char(OP_LOOKUP, 8'($urandom_range(255)), 1'b1);
    send_word(to_word("Pressure"), OP_INSERT);
    drain();
  endtask

  function automatic logic [7:0] random_char();
    int pick;
    string letters;
    letters = "aAbB";
    pick = $urandom_range(99);
    if (pick < 70) return letters[$urandom_range(3)];
    if (pick < 90) return 8'($urandom_range(65, 90)) | ($urandom_range(1) ? 8'h20 : 8'h00);
    return 8'($urandom_range(255));
  endfunction

  task automatic test_random_words(input int item_goal);
    word_t w;
    int len;
    int pick;
    int clears;
    logic [1:0] op;
    logic [7:0] c;
    clears = 0;
    item_goal += sent_items;
    while (sent_items < item_goal) begin
      pick = $urandom_range(999);
      if (pick < 4 && clears < 2) begin
        clears++;
        send_char($urandom_range(1) ? OP_CLEAR : OP_SPARE, 8'($urandom_range(255)),
                  1'($urandom_range(1)));
        continue;
      end
      op = $urandom_range(1) ? OP_INSERT : OP_LOOKUP;
      w.delete();
      if (op == OP_LOOKUP && known_words.size() != 0 && $urandom_range(1)) begin
        w = known_words[$urandom_range(known_words.size() - 1)];
        foreach (w[i]) if ($urandom_range(1) && ((w[i] | 8'h20) inside {["a":"z"]}))
          w[i] = w[i] ^ 8'h20;
      end else begin
        pick = $urandom_range(99);
        len = (pick < 90) ? $urandom_range(1, 8) :
              (pick < 97) ? $urandom_range(9, MAX_WORD_LEN) :
                            $urandom_range(MAX_WORD_LEN + 1, 50);
        repeat (len) w.push_back(random_char());
        if (op == OP_INSERT && known_words.size() < 64) known_words.push_back(w);
      end
      // Earlier characters carry a random insert or lookup code.
      foreach (w[i]) begin
        c = w[i];
        if (i == w.size() - 1) send_char(op, c, 1'b1);
        else send_char($urandom_range(1) ? OP_INSERT : OP_LOOKUP, c, 1'b0);
      end
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    pool_count = 0;
    pending_long = 1'b0;
    sent_items = 0;
    rx_hold = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = OP_INSERT;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    tx_idle_pct = 6;
    rx_idle_pct = 45;
    test_case_folding();
    test_odd_bytes();
    test_clear();
    test_word_length();
    test_random_words(300);

    tx_idle_pct = 45;
    rx_idle_pct = 6;
    test_random_words(300);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_words(300);
    test_back_pressure();
    test_full_pool();
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
